// ===== sv/normalised_name_hash16_assert.svh =====
// Assertion macros shared by the normalised name hash modules.
`ifndef NORMALISED_NAME_HASH16_ASSERT_SVH
`define NORMALISED_NAME_HASH16_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold on every clock edge outside reset.
`define NNH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// Implication checked in the same cycle.
`define NNH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`else

`define NNH_ASSERT(lbl, clk, rstn, prop)
`define NNH_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/nnh_pkg.sv =====
// Types, constants and helper functions for the normalised name hash.
package nnh_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;

    // One queued hash operation: optional deferred space, optional character,
    // and the end-of-name marker.
    typedef struct packed {
        logic       sp;
        logic       ch_v;
        logic [7:0] ch;
        logic       last;
    } op_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] c);
        return 32'((h ^ {24'd0, c}) * FNV_PRIME);
    endfunction

    // XOR fold to 16 bits; zero is reserved for the empty name.
    function automatic logic [15:0] fold16(input logic [31:0] h);
        logic [15:0] f;
        f = h[31:16] ^ h[15:0];
        return (f == 16'd0) ? 16'd1 : f;
    endfunction

endpackage

// ===== sv/nnh_front.sv =====
// Front end: accepts name bytes, normalises them and queues hash operations.
module nnh_front #(
    parameter int NAME_MAX = 32,
    parameter int CW       = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               s_tlast,
    input  logic               q_full,
    output logic               q_push,
    output nnh_pkg::op_t       q_op,
    output logic [CW-1:0]      q_len
);

    localparam logic [CW-1:0] MAX_CNT = CW'(NAME_MAX);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic          closed_reg, closed_next;
    logic          accept;
    logic [7:0]    c;
    nnh_pkg::op_t  op;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    always_comb begin
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        closed_next = closed_reg;
        op          = '0;
        if (s_tuser && !closed_reg) begin
            priority if (c == nnh_pkg::CHAR_NUL) begin
                closed_next = 1'b1;
            end else if (nnh_pkg::is_ws(c)) begin
                if (cnt_reg != '0) pend_next = 1'b1;
            end else if (pend_reg && cnt_reg >= MAX_CNT) begin
                closed_next = 1'b1;
            end else begin
                // deferred space goes first, even if the character then overflows
                if (pend_reg) begin
                    op.sp     = 1'b1;
                    pend_next = 1'b0;
                    cnt_next  = cnt_next + CW'(1);
                end
                if (cnt_next >= MAX_CNT) begin
                    closed_next = 1'b1;
                end else begin
                    op.ch_v  = 1'b1;
                    op.ch    = nnh_pkg::to_lower(c);
                    cnt_next = cnt_next + CW'(1);
                end
            end
        end
        op.last = s_tlast;
    end

    assign q_op   = op;
    assign q_len  = cnt_next;
    assign q_push = accept && (op.sp || op.ch_v || op.last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            closed_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                cnt_reg    <= '0;
                pend_reg   <= 1'b0;
                closed_reg <= 1'b0;
            end else begin
                cnt_reg    <= cnt_next;
                pend_reg   <= pend_next;
                closed_reg <= closed_next;
            end
        end
    end

endmodule

// ===== sv/nnh_fifo.sv =====
// Small register queue between the front and back ends.
`include "normalised_name_hash16_assert.svh"

module nnh_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [NW-1:0]    count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PW'(1);
            if (pop)  rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PW'(1);
            if (push && !pop)      count_reg <= count_reg + NW'(1);
            else if (pop && !push) count_reg <= count_reg - NW'(1);
        end
    end

    `NNH_ASSERT(a_count_bound, aclk, aresetn, count_reg <= NW'(DEPTH))
    `NNH_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, !empty)
    `NNH_ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, !full)

endmodule

// ===== sv/nnh_back.sv =====
// Back end: runs FNV-1a rounds for queued operations and holds the result.
`include "normalised_name_hash16_assert.svh"

module nnh_back #(
    parameter int CW = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  nnh_pkg::op_t  q_op,
    input  logic [CW-1:0] q_len,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   mesh_id,
    output logic [5:0]    norm_length
);

    logic [31:0]   hash_reg;
    logic          sp_done_reg, ch_done_reg;
    logic          out_valid_reg;
    logic [15:0]   out_id_reg;
    logic [5:0]    out_len_reg;
    logic          head_v, need_sp, need_ch, slot_free, emit;

    assign head_v    = !q_empty;
    assign need_sp   = q_op.sp && !sp_done_reg;
    assign need_ch   = q_op.ch_v && !ch_done_reg;
    assign slot_free = !out_valid_reg || m_tready;
    assign emit      = head_v && !need_sp && !need_ch && q_op.last && slot_free;

    always_comb begin
        q_pop = 1'b0;
        if (head_v) begin
            priority if (need_sp)              q_pop = 1'b0;
            else if (need_ch)                  q_pop = !q_op.last;
            else if (q_op.last)                q_pop = slot_free;
            else                               q_pop = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= nnh_pkg::FNV_BASIS;
            sp_done_reg   <= 1'b0;
            ch_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= emit || (out_valid_reg && !m_tready);
            if (head_v) begin
                priority if (need_sp) begin
                    hash_reg    <= nnh_pkg::fnv_round(hash_reg, nnh_pkg::CHAR_SPACE);
                    sp_done_reg <= 1'b1;
                end else if (need_ch) begin
                    hash_reg <= nnh_pkg::fnv_round(hash_reg, q_op.ch);
                    if (q_op.last) begin
                        ch_done_reg <= 1'b1;
                    end else begin
                        sp_done_reg <= 1'b0;
                    end
                end else if (q_op.last) begin
                    if (slot_free) begin
                        hash_reg    <= nnh_pkg::FNV_BASIS;
                        sp_done_reg <= 1'b0;
                        ch_done_reg <= 1'b0;
                    end
                end else begin
                    sp_done_reg <= 1'b0;
                    ch_done_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_id_reg  <= (q_len == '0) ? 16'd0 : nnh_pkg::fold16(hash_reg);
            out_len_reg <= 6'(q_len);
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign mesh_id     = out_id_reg;
    assign norm_length = out_len_reg;

    `NNH_ASSERT_IMPL(a_done_needs_head, aclk, aresetn, sp_done_reg || ch_done_reg, head_v)
    `NNH_ASSERT_IMPL(a_emit_slot_free, aclk, aresetn, q_pop && q_op.last,
                     !out_valid_reg || m_tready)
    `NNH_ASSERT_IMPL(a_pop_needs_head, aclk, aresetn, q_pop, head_v)

endmodule

// ===== sv/normalised_name_hash16.sv =====
// Normalised name hash: top level joining front end, queue and hash back end.
//
// Input stream: one name byte per transaction on s_tdata; s_tuser marks the
// byte as present (0 for an empty closing transaction); s_tlast closes the name.
// Bytes are trimmed, inner whitespace runs collapse to one space, A-Z are
// lowercased, and at most NAME_MAX characters are kept; a zero byte ends the name.
// Result stream: one transaction per name, after the s_tlast transaction:
// 32-bit FNV-1a of the kept characters XOR-folded to 16 bits (0 for an empty
// name, never 0 otherwise) and the normalised length.
// Throughput: the front end takes one transaction per cycle while the queue has
// room. The back end runs one FNV round per cycle while the queue head needs one:
// a queued transaction hashes its deferred space, if any, then its character,
// and the closing one forms the result when the output is free; transactions that
// add nothing to the hash and do not close the name are never queued.
// m_tvalid comes from a register that is set when the back end forms the result.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result
// and restarts the hash. When m_tready is low the result stays registered, the
// queue fills and s_tready then drops.
module normalised_name_hash16 #(
    parameter int NAME_MAX    = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] name_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] mesh_id, [21:16] norm_length, [23:22] zero
);

    localparam int CW = $clog2(NAME_MAX + 1);
    localparam int QW = $bits(nnh_pkg::op_t) + CW;

    logic               q_push, q_pop, q_full, q_empty;
    nnh_pkg::op_t       f_op, b_op;
    logic [CW-1:0]      f_len, b_len;
    logic [QW-1:0]      q_rdata;
    logic [15:0]        mesh_id;
    logic [5:0]         norm_length;

    nnh_front #(.NAME_MAX(NAME_MAX), .CW(CW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (f_op),
        .q_len    (f_len)
    );

    nnh_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH(QW)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_len, f_op}),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign b_op  = nnh_pkg::op_t'(q_rdata[$bits(nnh_pkg::op_t)-1:0]);
    assign b_len = q_rdata[QW-1:$bits(nnh_pkg::op_t)];

    nnh_back #(.CW(CW)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_op        (b_op),
        .q_len       (b_len),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .mesh_id     (mesh_id),
        .norm_length (norm_length)
    );

    assign m_tdata = {2'b00, norm_length, mesh_id};

endmodule

// ===== tb/sv/name_hash_checker.sv =====
// Checker for the normalised name hash: predicts each name's id and length and compares.
module name_hash_checker #(
    parameter int NAME_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] name_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [15:0] mesh_id, [21:16] norm_length, [23:22] zero
    output int          fail_count,
    output int          results_due
);

    typedef struct packed {
        logic [15:0] mesh_id;
        logic [5:0]  norm_length;
    } name_result_t;

    name_result_t id_q[$];

    // Running normalisation and hash state of the name in progress
    int          kept_chars;
    logic        space_due;
    logic [31:0] fnv_state;
    logic        name_closed;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == nnh_pkg::CHAR_SPACE) ||
               (c >= nnh_pkg::CHAR_TAB && c <= nnh_pkg::CHAR_CR);
    endfunction

    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] p;
        p = (h ^ {24'd0, c}) * nnh_pkg::FNV_PRIME;
        return p;
    endfunction

    function automatic void restart_name();
        kept_chars  = 0;
        space_due   = 1'b0;
        fnv_state   = nnh_pkg::FNV_BASIS;
        name_closed = 1'b0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] c);
        if (name_closed) return;
        if (c == nnh_pkg::CHAR_NUL) begin
            name_closed = 1'b1;
            return;
        end
        if (is_blank(c)) begin
            if (kept_chars > 0) space_due = 1'b1;
            return;
        end
        // a deferred space that still fits is kept even if c then does not
        if (space_due) begin
            if (kept_chars >= NAME_MAX) begin
                name_closed = 1'b1;
                return;
            end
            fnv_state = fnv_mix(fnv_state, nnh_pkg::CHAR_SPACE);
            kept_chars++;
            space_due = 1'b0;
        end
        if (kept_chars >= NAME_MAX) begin
            name_closed = 1'b1;
            return;
        end
        if (c >= nnh_pkg::CHAR_UPPER_A && c <= nnh_pkg::CHAR_UPPER_Z)
            c = c + nnh_pkg::CASE_OFFSET;
        fnv_state = fnv_mix(fnv_state, c);
        kept_chars++;
    endfunction

    function automatic name_result_t close_name();
        name_result_t r;
        logic [15:0]  folded;
        folded = fnv_state[31:16] ^ fnv_state[15:0];
        if (kept_chars == 0) r.mesh_id = 16'd0;
        else if (folded == 16'd0) r.mesh_id = 16'd1;
        else r.mesh_id = folded;
        r.norm_length = kept_chars[5:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        name_result_t want;
        if (!aresetn) begin
            restart_name();
            id_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (id_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = id_q.pop_front();
                    if (m_tdata[15:0] !== want.mesh_id) begin
                        $display("%0t: mesh_id mismatch, expected %h, actual %h",
                                 $time, want.mesh_id, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[21:16] !== want.norm_length) begin
                        $display("%0t: norm_length mismatch, expected %0d, actual %0d",
                                 $time, want.norm_length, m_tdata[21:16]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) absorb_byte(s_tdata);
                if (s_tlast) begin
                    id_q.push_back(close_name());
                    restart_name();
                end
            end
        end
        results_due = id_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the name hash testbench: clock, reset, name stimulus, result sink and verdict.
module testbench;

    localparam int NAME_MAX     = 32;
    localparam int IDLE_LIMIT   = 1000;
    localparam int ITEM_TARGET  = 1550;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } name_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int          fail_count;
    int          results_due;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    bit          no_idle     = 1'b0;
    name_item_t  items_q[$];

    always #6 aclk = ~aclk;

    normalised_name_hash16 #(.NAME_MAX(NAME_MAX)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    name_hash_checker #(.NAME_MAX(NAME_MAX)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    task automatic add_item(input logic [7:0] data, input logic has, input logic last);
        items_q.push_back(name_item_t'{data, has, last});
    endtask

    // Sends the queued items, one transaction each, with a random gap before each unless no_idle is set
    task automatic send_name();
        name_item_t it;
        int         gap;
        while (items_q.size() > 0) begin
            it  = items_q.pop_front();
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.data;
            s_tuser  <= it.has;
            s_tlast  <= it.last;
            do @(posedge aclk); while (!s_tready);
            items_sent++;
        end
    endtask

    // Hold the input off until every predicted result has been taken
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte(input bit plain);
        int r;
        r = $urandom_range(0, 99);
        if (plain) r = r % 55;
        if (r < 30) return 8'($urandom_range(8'h41, 8'h5A));
        if (r < 55) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 68) return (r < 62) ? nnh_pkg::CHAR_SPACE : 8'($urandom_range(8'h09, 8'h0D));
        if (r < 70) return nnh_pkg::CHAR_NUL;
        return 8'($urandom_range(1, 255));
    endfunction

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int  shape;
        int  len;
        logic [7:0] b;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty closing transaction alone: empty name
        add_item(8'h5A, 1'b0, 1'b1);
        // top-bit byte kept as is
        add_item(8'hFF, 1'b1, 1'b1);
        // leading, inner and trailing whitespace, upper case
        add_item(nnh_pkg::CHAR_TAB, 1'b1, 1'b0);
        add_item(8'h41, 1'b1, 1'b0);
        add_item(nnh_pkg::CHAR_SPACE, 1'b1, 1'b0);
        add_item(8'h0B, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h0A, 1'b1, 1'b1);
        // zero byte closes the name, later bytes ignored
        add_item(8'h5A, 1'b1, 1'b0);
        add_item(nnh_pkg::CHAR_NUL, 1'b1, 1'b0);
        add_item(8'h51, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        // transaction without a byte inside a name
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'hC3, 1'b0, 1'b0);
        add_item(8'h5A, 1'b1, 1'b1);
        // whitespace only
        add_item(nnh_pkg::CHAR_SPACE, 1'b1, 1'b0);
        add_item(nnh_pkg::CHAR_CR, 1'b1, 1'b0);
        add_item(8'h0B, 1'b1, 1'b0);
        add_item(8'h0C, 1'b1, 1'b1);
        // bytes just outside the letter ranges and around 0x80
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'h7F, 1'b1, 1'b0);
        add_item(8'h40, 1'b1, 1'b0);
        add_item(8'h5B, 1'b1, 1'b0);
        add_item(8'h60, 1'b1, 1'b0);
        add_item(8'h7B, 1'b1, 1'b1);
        send_name();
        hold_until_drained();

        while (items_sent < ITEM_TARGET) begin
            no_idle = ($urandom_range(0, 99) < 20);
            shape   = $urandom_range(0, 99);
            if (shape < 60) begin
                repeat ($urandom_range(0, 2)) add_item(pick_byte(1'b0) | 8'h20, 1'b1, 1'b0);
                len = $urandom_range(1, 12);
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
                    else add_item(pick_byte(1'b0), 1'b1, 1'b0);
                end
                repeat ($urandom_range(0, 2)) add_item(nnh_pkg::CHAR_SPACE, 1'b1, 1'b0);
            end else if (shape < 75) begin
                len = $urandom_range(28, 40);
                repeat (len) begin
                    b = ($urandom_range(0, 99) < 15) ? nnh_pkg::CHAR_SPACE : pick_byte(1'b1);
                    add_item(b, 1'b1, 1'b0);
                end
            end else if (shape < 85) begin
                // fill to within two characters of the length limit, then whitespace and more characters
                len = NAME_MAX - $urandom_range(0, 2);
                repeat (len) add_item(pick_byte(1'b1), 1'b1, 1'b0);
                repeat ($urandom_range(1, 2)) add_item(nnh_pkg::CHAR_SPACE, 1'b1, 1'b0);
                repeat ($urandom_range(1, 3)) add_item(pick_byte(1'b1), 1'b1, 1'b0);
            end else begin
                len = $urandom_range(1, 20);
                repeat (len) add_item(8'($urandom), 1'($urandom), 1'b0);
            end
            if ($urandom_range(0, 3) == 0) add_item(8'($urandom), 1'b0, 1'b1);
            else items_q[items_q.size() - 1].last = 1'b1;
            send_name();
            if ($urandom_range(0, 29) == 0) hold_until_drained();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/nnh_pkg.sv
sv/nnh_front.sv
sv/nnh_fifo.sv
sv/nnh_back.sv
sv/normalised_name_hash16.sv
tb/sv/name_hash_checker.sv
tb/sv/testbench.sv
